FILE: sv/chm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash map package
// Sizes, operation codes, bucket row layout and miss value shared by the
// hash map unit, its modulo unit and its testbench.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int BUCKETS = 32;
	localparam int WAYS    = 4;

	localparam int KEY_W  = 31;
	localparam int VAL_W  = 32;
	localparam int FUNC_W = 2;
	localparam int CFG_W  = 6;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(20);

	localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W    = $clog2(BUCKETS + 1);
	localparam int STEP_W   = BUCKET_W + 1;

	localparam int DIGIT_W     = 4;
	localparam int DIGITS      = (KEY_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W       = DIGITS * DIGIT_W;
	localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

	localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

endpackage
`default_nettype wire

FILE: sv/chm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                      clk,
	input  wire                                      we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                          wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: sv/chm_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash map modulo unit
// Reduces a key modulo the bucket count, one hex digit of the key per cycle
// through four restoring compare-subtract steps.
// ----------------------------------------------------------------------------
module chm_mod (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [chm_pkg::KEY_W-1:0]     key,
	input  wire [chm_pkg::CNT_W-1:0]     modulus,
	output logic                         done,
	output logic [chm_pkg::BUCKET_W-1:0] rem
);

	import chm_pkg::*;

	logic [PAD_W-1:0]       shreg_q;
	logic [CNT_W-1:0]       n_q;
	logic [BUCKET_W-1:0]    rem_q;
	logic [DIGIT_CNT_W-1:0] cnt_q;
	logic                   done_q;
	logic [BUCKET_W-1:0]    rem_next;
	logic [STEP_W-1:0]      t;
	logic [BUCKET_W-1:0]    r;

	always_comb begin
		r = rem_q;
		t = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			t = {r, shreg_q[PAD_W-1-i]};
			if (t >= STEP_W'(n_q)) begin
				t = t - STEP_W'(n_q);
			end
			r = t[BUCKET_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= PAD_W'(key);
			n_q     <= modulus;
			rem_q   <= '0;
		end else if (cnt_q != '0) begin
			shreg_q <= shreg_q << DIGIT_W;
			rem_q   <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIGIT_CNT_W'(DIGITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIGIT_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

FILE: sv/chained_hash_map_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash map unit
// Key-value store of BUCKETS buckets with WAYS slots each. Bucket rows live in
// one RAM; slot valid bits live in flip-flops. Each transaction does set, get
// or remove on one key and returns one result transaction.
// ----------------------------------------------------------------------------
// Flow: one transaction at a time, taken only while idle; the modulo unit
//   reduces the key four key bits per cycle, then one RAM row read and, for a
//   set that changes the row, one write-back.
// Reset: all slots invalid at once, bucket_count back to 20, no clearing pass.
// ----------------------------------------------------------------------------
module chained_hash_map_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [chm_pkg::CFG_W-1:0]          bucket_count,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [chm_pkg::FUNC_W-1:0]         func,
	input  wire [chm_pkg::KEY_W-1:0]          key,
	input  wire signed [chm_pkg::VAL_W-1:0]   value,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic                              found,
	output logic signed [chm_pkg::VAL_W-1:0]  read_value,
	output logic                              bucket_full
);

	import chm_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_LOOK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]              state_q;
	logic [CFG_W-1:0]        bucket_count_q;
	logic [CNT_W-1:0]        eff_count;
	logic [WAYS-1:0]         valid_q [BUCKETS];

	logic [FUNC_W-1:0]       func_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] value_q;

	logic                    res_found_q;
	logic signed [VAL_W-1:0] res_value_q;
	logic                    res_full_q;

	logic                    out_valid_q;
	logic                    found_q;
	logic signed [VAL_W-1:0] read_value_q;
	logic                    bucket_full_q;

	logic                    in_accept;
	logic                    mod_done;
	logic [BUCKET_W-1:0]     mod_rem;
	logic [ROW_W-1:0]        ram_rdata;
	logic                    ram_we;

	row_t                    row;
	row_t                    new_row;
	logic [WAYS-1:0]         vrow;
	logic [WAYS-1:0]         new_vrow;
	logic                    hit;
	logic                    free;
	logic [WAY_W-1:0]        hit_idx;
	logic [WAY_W-1:0]        free_idx;
	logic                    we_c;
	logic                    found_c;
	logic signed [VAL_W-1:0] rd_c;
	logic                    full_c;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;

	always_comb begin
		if (bucket_count_q == '0) begin
			eff_count = CNT_W'(1);
		end else if (int'(bucket_count_q) > BUCKETS) begin
			eff_count = CNT_W'(BUCKETS);
		end else begin
			eff_count = CNT_W'(bucket_count_q);
		end
	end

	chm_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_accept),
		.key     (key),
		.modulus (eff_count),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	chm_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (mod_rem),
		.wdata (new_row),
		.raddr (mod_rem),
		.rdata (ram_rdata)
	);

	always_comb begin
		row      = row_t'(ram_rdata);
		vrow     = valid_q[mod_rem];
		hit      = 1'b0;
		free     = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (vrow[w] && (row[w].key == key_q)) begin
				hit     = 1'b1;
				hit_idx = WAY_W'(w);
			end
			if (!vrow[w]) begin
				free     = 1'b1;
				free_idx = WAY_W'(w);
			end
		end

		new_row  = row;
		new_vrow = vrow;
		we_c     = 1'b0;
		found_c  = 1'b0;
		rd_c     = MISS_VALUE;
		full_c   = 1'b0;
		case (func_q)
			FUNC_SET: begin
				if (hit) begin
					new_row[hit_idx].value = value_q;
					found_c                = 1'b1;
					we_c                   = 1'b1;
				end else if (free) begin
					new_row[free_idx].key   = key_q;
					new_row[free_idx].value = value_q;
					new_vrow[free_idx]      = 1'b1;
					we_c                    = 1'b1;
				end else begin
					full_c = 1'b1;
				end
			end
			FUNC_GET: begin
				if (hit) begin
					found_c = 1'b1;
					rd_c    = row[hit_idx].value;
				end
			end
			FUNC_REMOVE: begin
				if (hit) begin
					found_c           = 1'b1;
					new_vrow[hit_idx] = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_we = (state_q == S_LOOK) && we_c;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q  <= func;
			key_q   <= key;
			value_q <= value;
		end
		if (state_q == S_LOOK) begin
			res_found_q <= found_c;
			res_value_q <= rd_c;
			res_full_q  <= full_c;
		end
		if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
			found_q       <= res_found_q;
			read_value_q  <= res_value_q;
			bucket_full_q <= res_full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			bucket_count_q <= CFG_RESET;
			out_valid_q    <= 1'b0;
			for (int b = 0; b < BUCKETS; b++) begin
				valid_q[b] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				bucket_count_q <= bucket_count;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					valid_q[mod_rem] <= new_vrow;
					state_q          <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign read_value  = read_value_q;
	assign bucket_full = bucket_full_q;

	a_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_MOD))
		else $error("modulo done outside modulo wait");

	a_bucket_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK) |-> (CNT_W'(mod_rem) < eff_count))
		else $error("bucket index beyond bucket count");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (read_value == MISS_VALUE))
		else $error("miss result without miss value");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && bucket_full))
		else $error("full flag on a hit");

endmodule
`default_nettype wire

FILE: bench/chained_hash_map_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash map unit testbench
// Drives set, get and remove transactions into the hash map through random
// sender gaps and receiver stalls, predicts each result with a bucketed store
// kept alongside, and checks every result field in order. Covers the register
// extremes, full buckets, unknown operations and a long receiver hold-off.
// ----------------------------------------------------------------------------
module chained_hash_map_unit_test;

	import chm_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int SLOTS     = BUCKETS * WAYS;
	localparam int POOL_SIZE = 24;

	typedef struct {
		logic                    found;
		logic signed [VAL_W-1:0] read_value;
		logic                    bucket_full;
	} map_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        bucket_count;
	logic                    in_valid;
	logic                    in_ready;
	logic [FUNC_W-1:0]       func;
	logic [KEY_W-1:0]        key;
	logic signed [VAL_W-1:0] value;
	logic                    out_valid;
	logic                    out_ready;
	logic                    found;
	logic signed [VAL_W-1:0] read_value;
	logic                    bucket_full;

	logic [KEY_W-1:0]        map_key [SLOTS];
	logic signed [VAL_W-1:0] map_value [SLOTS];
	logic                    map_valid [SLOTS];
	logic [CFG_W-1:0]        map_buckets;

	map_result_t             expected_results [$];
	logic [KEY_W-1:0]        key_pool [POOL_SIZE];
	int                      mismatch_count;
	int                      hold_cycles;
	bit                      tx_quiet;
	bit                      rx_quiet;

	chained_hash_map_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.bucket_count (bucket_count),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.key          (key),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.read_value   (read_value),
		.bucket_full  (bucket_full)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int unsigned active_buckets();
		int unsigned n;
		n = map_buckets;
		if (n == 0)
			n = 1;
		if (n > BUCKETS)
			n = BUCKETS;
		return n;
	endfunction

	function automatic map_result_t apply_map_op(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k,
			logic signed [VAL_W-1:0] v);
		map_result_t res;
		int unsigned base;
		int          hit;
		int          free_slot;
		hit       = -1;
		free_slot = -1;
		base      = (int'(k) % active_buckets()) * WAYS;
		res.found       = 1'b0;
		res.read_value  = MISS_VALUE;
		res.bucket_full = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (map_valid[base + w]) begin
				if (hit < 0 && map_key[base + w] == k)
					hit = base + w;
			end else if (free_slot < 0) begin
				free_slot = base + w;
			end
		end
		case (op)
			FUNC_SET: begin
				if (hit >= 0) begin
					map_value[hit] = v;
					res.found = 1'b1;
				end else if (free_slot >= 0) begin
					map_key[free_slot]   = k;
					map_value[free_slot] = v;
					map_valid[free_slot] = 1'b1;
				end else begin
					res.bucket_full = 1'b1;
				end
			end
			FUNC_GET: begin
				if (hit >= 0) begin
					res.found      = 1'b1;
					res.read_value = map_value[hit];
				end
			end
			FUNC_REMOVE: begin
				if (hit >= 0) begin
					res.found      = 1'b1;
					map_valid[hit] = 1'b0;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic enqueue_expected(map_result_t res);
		expected_results = {expected_results, res};
	endtask

	task automatic send_op(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] k,
			logic signed [VAL_W-1:0] v);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		key      <= k;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		enqueue_expected(apply_map_op(op, k, v));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_bucket_count(logic [CFG_W-1:0] n);
		drain_results();
		@(negedge clk);
		cfg_valid    <= 1'b1;
		bucket_count <= n;
		do @(posedge clk); while (!cfg_ready);
		map_buckets = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic fill_key_pool();
		int unsigned n;
		n = active_buckets();
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i < POOL_SIZE / 2)
				key_pool[i] = KEY_W'($urandom_range(0, 2) + n * $urandom_range(0, 7));
			else
				key_pool[i] = KEY_W'($urandom);
		end
	endtask

	task automatic send_random_ops(int count);
		int                      r;
		logic [FUNC_W-1:0]       op;
		logic [KEY_W-1:0]        k;
		logic signed [VAL_W-1:0] v;
		fill_key_pool();
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				op = FUNC_SET;
			else if (r < 75)
				op = FUNC_GET;
			else if (r < 95)
				op = FUNC_REMOVE;
			else
				op = FUNC_NONE;
			if ($urandom_range(0, 9) == 0)
				k = KEY_W'($urandom);
			else
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			v = $urandom;
			send_op(op, k, v);
		end
	endtask

	// default modulus of 20: field extremes, hit and miss, full bucket
	task automatic test_default_buckets();
		send_op(FUNC_SET, '0, 32'sh7FFFFFFF);
		send_op(FUNC_GET, '0, '0);
		send_op(FUNC_SET, '1, 32'sh80000000);
		send_op(FUNC_GET, '1, '1);
		send_op(FUNC_SET, '0, '0);
		send_op(FUNC_REMOVE, '0, '0);
		send_op(FUNC_GET, '0, '0);
		send_op(FUNC_REMOVE, '0, '0);
		send_op(FUNC_NONE, 31'd5, 32'sd77);
		for (int i = 0; i < 5; i++)
			send_op(FUNC_SET, KEY_W'(5 + 20 * i), VAL_W'(100 + i));
		send_op(FUNC_REMOVE, 31'd25, '0);
		send_op(FUNC_SET, 31'd85, -32'sd9);
	endtask

	// modulus zero and saturation, entries left behind across changes
	task automatic test_bucket_count_extremes();
		write_bucket_count('0);
		for (int i = 1; i <= 5; i++)
			send_op(FUNC_SET, KEY_W'(i), VAL_W'(i * 3));
		write_bucket_count('1);
		send_op(FUNC_GET, 31'd5, '0);
		send_op(FUNC_GET, 31'd4, '0);
		write_bucket_count(CFG_W'(BUCKETS));
		send_op(FUNC_GET, 31'd37, '0);
		write_bucket_count(CFG_W'(1));
		send_op(FUNC_GET, 31'd3, '0);
	endtask

	task automatic test_output_backpressure();
		write_bucket_count(CFG_W'(3));
		fill_key_pool();
		hold_cycles = 160;
		tx_quiet    = 1'b1;
		for (int i = 0; i < 24; i++)
			send_op((i % 2 == 0) ? FUNC_SET : FUNC_GET, key_pool[i % 8], VAL_W'($urandom));
		tx_quiet = 1'b0;
	endtask

	task automatic test_random_settings();
		logic [CFG_W-1:0] settings [7];
		settings = '{CFG_W'(1), CFG_W'(2), CFG_W'(7), CFG_W'(BUCKETS), '1, CFG_RESET,
			CFG_W'($urandom_range(1, 63))};
		for (int p = 0; p < 7; p++) begin
			write_bucket_count(settings[p]);
			tx_quiet = (p == 3);
			rx_quiet = (p == 3);
			send_random_ops(130);
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else if (!rx_quiet) begin
				int stall;
				stall = $urandom_range(0, 8);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: found=%0b read_value=%0d bucket_full=%0b",
					found, read_value, bucket_full);
				mismatch_count++;
			end else begin
				map_result_t exp_res;
				exp_res = expected_results.pop_front();
				if (found !== exp_res.found) begin
					$error("found: expected %0b, actual %0b", exp_res.found, found);
					mismatch_count++;
				end
				if (read_value !== exp_res.read_value) begin
					$error("read_value: expected %0d, actual %0d", exp_res.read_value, read_value);
					mismatch_count++;
				end
				if (bucket_full !== exp_res.bucket_full) begin
					$error("bucket_full: expected %0b, actual %0b", exp_res.bucket_full,
						bucket_full);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		bucket_count   = CFG_RESET;
		in_valid       = 1'b0;
		func           = FUNC_SET;
		key            = '0;
		value          = '0;
		mismatch_count = 0;
		hold_cycles    = 0;
		tx_quiet       = 1'b0;
		rx_quiet       = 1'b0;
		map_buckets    = CFG_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			map_key[i]   = '0;
			map_value[i] = '0;
			map_valid[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_buckets();
		test_bucket_count_extremes();
		test_output_backpressure();
		test_random_settings();

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
